// ===== rtl/core/cmfs_pkg.sv =====
// ----------------------------------------------------------------------------
// cmfs_pkg
// Shared types and constants for the cube map face select pipeline.
// ----------------------------------------------------------------------------
package cmfs_pkg;

  localparam int unsigned CompW    = 16;
  localparam int unsigned FracBits = 16;
  localparam int unsigned CoordW   = FracBits + 1;
  // sc + ma spans 0 .. 2^CompW, one bit wider than a component
  localparam int unsigned NumW     = CompW + 1;
  localparam int unsigned FaceW    = 3;

  localparam logic [FaceW-1:0] FacePosX = 3'd0;
  localparam logic [FaceW-1:0] FaceNegX = 3'd1;
  localparam logic [FaceW-1:0] FacePosY = 3'd2;
  localparam logic [FaceW-1:0] FaceNegY = 3'd3;
  localparam logic [FaceW-1:0] FacePosZ = 3'd4;
  localparam logic [FaceW-1:0] FaceNegZ = 3'd5;

  typedef struct packed {
    logic signed [CompW-1:0] dir_x;
    logic signed [CompW-1:0] dir_y;
    logic signed [CompW-1:0] dir_z;
  } dir_t;

  typedef struct packed {
    logic [FaceW-1:0]  face;
    logic [CoordW-1:0] coord_s;
    logic [CoordW-1:0] coord_t;
    logic              zero_vector;
  } result_t;

  // sideband that rides along the divider stages
  typedef struct packed {
    logic [FaceW-1:0] face;
    logic             zero_vector;
  } side_t;

endpackage

// ===== rtl/core/cmfs_div_pipe.sv =====
// ----------------------------------------------------------------------------
// cmfs_div_pipe
// Pipelined restoring divider, one quotient bit per stage, two numerators
// over a shared divisor. Quotient = floor(num * 2^(FracBits-1) / div).
// ----------------------------------------------------------------------------
module cmfs_div_pipe import cmfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [NumW-1:0]   num_s_i,
  input  logic [NumW-1:0]   num_t_i,
  input  logic [CompW-1:0]  div_i,
  input  side_t             side_i,
  output logic              valid_o,
  output logic [CoordW-1:0] quo_s_o,
  output logic [CoordW-1:0] quo_t_o,
  output side_t             side_o
);

  logic              valid_q [CoordW];
  logic [NumW-1:0]   rem_s_q [CoordW];
  logic [NumW-1:0]   rem_t_q [CoordW];
  logic [CoordW-1:0] quo_s_q [CoordW];
  logic [CoordW-1:0] quo_t_q [CoordW];
  logic [CompW-1:0]  div_q   [CoordW];
  side_t             side_q  [CoordW];

  for (genvar k = 0; k < CoordW; k++) begin : g_stage
    logic              v_in;
    logic [NumW-1:0]   rs_in;
    logic [NumW-1:0]   rt_in;
    logic [CompW-1:0]  d_in;
    logic [CoordW-1:0] qs_in;
    logic [CoordW-1:0] qt_in;
    side_t             sd_in;
    logic [NumW-1:0]   cmp_d;
    logic [NumW-1:0]   ts;
    logic [NumW-1:0]   tt;
    logic              bs;
    logic              bt;
    logic [NumW-1:0]   rs_nx;
    logic [NumW-1:0]   rt_nx;

    if (k == 0) begin : g_first
      assign v_in  = valid_i;
      assign rs_in = num_s_i;
      assign rt_in = num_t_i;
      assign d_in  = div_i;
      assign qs_in = '0;
      assign qt_in = '0;
      assign sd_in = side_i;
    end else begin : g_next
      assign v_in  = valid_q[k-1];
      assign rs_in = rem_s_q[k-1];
      assign rt_in = rem_t_q[k-1];
      assign d_in  = div_q[k-1];
      assign qs_in = quo_s_q[k-1];
      assign qt_in = quo_t_q[k-1];
      assign sd_in = side_q[k-1];
    end

    // first two stages form the integer part (0..2), the rest shift in zeros
    always_comb begin
      if (k == 0) begin
        cmp_d = {d_in, 1'b0};
        ts    = rs_in;
        tt    = rt_in;
      end else if (k == 1) begin
        cmp_d = {1'b0, d_in};
        ts    = rs_in;
        tt    = rt_in;
      end else begin
        cmp_d = {1'b0, d_in};
        ts    = {rs_in[NumW-2:0], 1'b0};
        tt    = {rt_in[NumW-2:0], 1'b0};
      end
      bs    = (ts >= cmp_d);
      bt    = (tt >= cmp_d);
      rs_nx = bs ? (ts - cmp_d) : ts;
      rt_nx = bt ? (tt - cmp_d) : tt;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_s_q[k] <= rs_nx;
      rem_t_q[k] <= rt_nx;
      quo_s_q[k] <= {qs_in[CoordW-2:0], bs};
      quo_t_q[k] <= {qt_in[CoordW-2:0], bt};
      div_q[k]   <= d_in;
      side_q[k]  <= sd_in;
    end
  end

  assign valid_o = valid_q[CoordW-1];
  assign quo_s_o = quo_s_q[CoordW-1];
  assign quo_t_o = quo_t_q[CoordW-1];
  assign side_o  = side_q[CoordW-1];

endmodule

// ===== rtl/core/cube_map_face_select_top.sv =====
// ----------------------------------------------------------------------------
// cube_map_face_select_top
// Cube map face selection: major axis, face and fixed-point s/t coordinates.
// ----------------------------------------------------------------------------
// Takes one direction word per clock and returns one result word per word,
// in order. busy_o is never raised, so a new word can be started every
// cycle. The s/t divider resolves one quotient bit per pipeline stage (17
// stages); ahead of it sit four front stages (input, magnitude, axis select,
// numerator), and the output register follows it.
// done_o pulses for one cycle with the result; the receiver cannot stall.
// A zero vector sets zero_vector with face and coordinates zero.
module cube_map_face_select_top import cmfs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  dir_t    dir_i,
  output logic    busy_o,
  output logic    done_o,
  output result_t result_o
);

  // stage A: input capture
  logic a_valid_q;
  dir_t a_dir_q;

  // stage B: magnitudes
  logic             b_valid_q;
  dir_t             b_dir_q;
  logic [CompW-1:0] b_ax_q, b_ay_q, b_az_q;
  logic [CompW-1:0] b_ax_d, b_ay_d, b_az_d;

  // stage C: axis select
  logic                   c_valid_q;
  logic signed [NumW-1:0] c_sc_q, c_tc_q;
  logic [CompW-1:0]       c_ma_q;
  side_t                  c_side_q;
  logic signed [NumW-1:0] c_sc_d, c_tc_d;
  logic [CompW-1:0]       c_ma_d;
  side_t                  c_side_d;

  // stage D: numerators
  logic             d_valid_q;
  logic [NumW-1:0]  d_num_s_q, d_num_t_q;
  logic [CompW-1:0] d_ma_q;
  side_t            d_side_q;

  logic              dv_valid;
  logic [CoordW-1:0] dv_quo_s, dv_quo_t;
  side_t             dv_side;

  logic    done_q;
  result_t result_q;
  result_t result_d;

  assign busy_o = 1'b0;

  // ---- stage B combinational: |x|, |y|, |z| (most negative stays exact) ----
  always_comb begin
    b_ax_d = a_dir_q.dir_x[CompW-1] ? (~a_dir_q.dir_x + 1'b1) : a_dir_q.dir_x;
    b_ay_d = a_dir_q.dir_y[CompW-1] ? (~a_dir_q.dir_y + 1'b1) : a_dir_q.dir_y;
    b_az_d = a_dir_q.dir_z[CompW-1] ? (~a_dir_q.dir_z + 1'b1) : a_dir_q.dir_z;
  end

  // ---- stage C combinational: major axis, face, sc/tc ----
  always_comb begin
    logic signed [NumW-1:0] sx, sy, sz;
    sx = {b_dir_q.dir_x[CompW-1], b_dir_q.dir_x};
    sy = {b_dir_q.dir_y[CompW-1], b_dir_q.dir_y};
    sz = {b_dir_q.dir_z[CompW-1], b_dir_q.dir_z};
    c_side_d.zero_vector = (b_ax_q == '0) && (b_ay_q == '0) && (b_az_q == '0);
    if (b_ax_q >= b_ay_q && b_ax_q >= b_az_q) begin
      c_ma_d = b_ax_q;
      c_tc_d = -sy;
      if (!sx[NumW-1]) begin
        c_side_d.face = FacePosX;
        c_sc_d        = -sz;
      end else begin
        c_side_d.face = FaceNegX;
        c_sc_d        = sz;
      end
    end else if (b_ay_q >= b_ax_q && b_ay_q >= b_az_q) begin
      c_ma_d = b_ay_q;
      c_sc_d = sx;
      if (!sy[NumW-1]) begin
        c_side_d.face = FacePosY;
        c_tc_d        = sz;
      end else begin
        c_side_d.face = FaceNegY;
        c_tc_d        = -sz;
      end
    end else begin
      c_ma_d = b_az_q;
      c_tc_d = -sy;
      if (!sz[NumW-1]) begin
        c_side_d.face = FacePosZ;
        c_sc_d        = sx;
      end else begin
        c_side_d.face = FaceNegZ;
        c_sc_d        = -sx;
      end
    end
  end

  // ---- output register: zero vector forces the fields clear ----
  always_comb begin
    if (dv_side.zero_vector) begin
      result_d = '0;
      result_d.zero_vector = 1'b1;
    end else begin
      result_d.face        = dv_side.face;
      result_d.coord_s     = dv_quo_s;
      result_d.coord_t     = dv_quo_t;
      result_d.zero_vector = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      a_valid_q <= start_i & ~busy_o;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
      done_q    <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    a_dir_q   <= dir_i;
    b_dir_q   <= a_dir_q;
    b_ax_q    <= b_ax_d;
    b_ay_q    <= b_ay_d;
    b_az_q    <= b_az_d;
    c_sc_q    <= c_sc_d;
    c_tc_q    <= c_tc_d;
    c_ma_q    <= c_ma_d;
    c_side_q  <= c_side_d;
    // sc + ma lies in 0 .. 2*ma, so the sum wraps back to the true value
    d_num_s_q <= $unsigned(c_sc_q) + {1'b0, c_ma_q};
    d_num_t_q <= $unsigned(c_tc_q) + {1'b0, c_ma_q};
    d_ma_q    <= c_ma_q;
    d_side_q  <= c_side_q;
    result_q  <= result_d;
  end

  cmfs_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid_q),
    .num_s_i (d_num_s_q),
    .num_t_i (d_num_t_q),
    .div_i   (d_ma_q),
    .side_i  (d_side_q),
    .valid_o (dv_valid),
    .quo_s_o (dv_quo_s),
    .quo_t_o (dv_quo_t),
    .side_o  (dv_side)
  );

  assign done_o   = done_q;
  assign result_o = result_q;

  // ---- assertions ----
  localparam logic [CoordW-1:0] CoordMax = {1'b1, {FracBits{1'b0}}};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.zero_vector |->
      result_o.face == FacePosX && result_o.coord_s == '0 && result_o.coord_t == '0)
    else $error("zero vector word carries nonzero fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.coord_s <= CoordMax && result_o.coord_t <= CoordMax)
    else $error("face coordinate above one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.face <= FaceNegZ)
    else $error("face code out of range");

endmodule
